// ----- src/bdq_pkg.sv -----
// Package for the bounded deque: action and status codes, result descriptor, defaults.
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int DATA_W        = 32;
	localparam int OCC_W         = 5;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_REAR  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_REAR   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// What the control stage hands to the read stage for one item.
	typedef struct packed {
		logic             pop_ok;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} res_t;

endpackage

// ----- src/bdq_in_if.sv -----
// Input channel of the deque: action and data word with valid/ready.
interface bdq_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] data_in;

	modport source (output valid, output action, output data_in, input ready);
	modport sink   (input valid, input action, input data_in, output ready);
endinterface

// ----- src/bdq_out_if.sv -----
// Result channel of the deque: popped word, status and occupancy with valid/ready.
interface bdq_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] data_out;
	logic [1:0]         status;
	logic [4:0]         occupancy;

	modport source (output valid, output data_out, output status, output occupancy,
		input ready);
	modport sink   (input valid, input data_out, input status, input occupancy,
		output ready);
endinterface

// ----- src/bdq_ram.sv -----
// Storage of the deque: single-port synchronous RAM with registered read data.
module bdq_ram #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic                          re,
	input  logic [AW-1:0]                 addr,
	input  logic [bdq_pkg::DATA_W-1:0]    wdata,
	output logic [bdq_pkg::DATA_W-1:0]    rdata
);
	import bdq_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
	end

	// Hold the last read word until the next read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- src/bdq_ctrl.sv -----
// Pointer and fill-count control: decodes an item, addresses the RAM, updates state.
module bdq_ctrl #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    action,
	input  logic [bdq_pkg::DATA_W-1:0]    data_in,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_addr,
	output logic [bdq_pkg::DATA_W-1:0]    mem_wdata,
	output bdq_pkg::res_t                 res
);
	import bdq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int XW = (CW > OCC_W) ? CW : OCC_W;

	logic [AW-1:0] head_q;
	logic [CW-1:0] fill_q;

	logic [AW-1:0] head_d;
	logic [CW-1:0] fill_d;
	logic          full;
	logic          empty;
	logic [AW-1:0] head_dec;
	logic [AW-1:0] head_inc;
	logic [SW-1:0] rear_sum;
	logic [SW-1:0] rear_wrap;
	logic [AW-1:0] rear_pos;
	logic          push_ok;
	logic          pop_ok;
	status_t       status;
	logic [XW-1:0] occ_ext;

	assign full  = (fill_q == CW'(DEPTH));
	assign empty = (fill_q == '0);

	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);

	// Rear slot: head + fill on push, one less on pop; below twice DEPTH unless empty.
	always_comb begin
		rear_sum = SW'(head_q) + SW'(fill_q);
		if (action_t'(action) == ACT_POP_REAR) begin
			rear_sum = rear_sum - SW'(1);
		end
		rear_wrap = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
		rear_pos  = rear_wrap[AW-1:0];
	end

	always_comb begin
		head_d   = head_q;
		fill_d   = fill_q;
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		status   = ST_DONE;
		mem_addr = rear_pos;
		unique case (action_t'(action))
			ACT_PUSH_FRONT: begin
				mem_addr = head_dec;
				if (full) begin
					status = ST_FULL;
				end else begin
					push_ok = 1'b1;
					head_d  = head_dec;
					fill_d  = fill_q + CW'(1);
				end
			end
			ACT_PUSH_REAR: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					push_ok = 1'b1;
					fill_d  = fill_q + CW'(1);
				end
			end
			ACT_POP_FRONT: begin
				mem_addr = head_q;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
					head_d = head_inc;
					fill_d = fill_q - CW'(1);
				end
			end
			ACT_POP_REAR: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
					fill_d = fill_q - CW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			head_q <= head_d;
			fill_q <= fill_d;
		end
	end

	assign mem_we    = accept && push_ok;
	assign mem_re    = accept && pop_ok;
	assign mem_wdata = data_in;

	assign occ_ext       = XW'(fill_d);
	assign res.pop_ok    = pop_ok;
	assign res.status    = status;
	assign res.occupancy = occ_ext[OCC_W-1:0];
endmodule

// ----- src/bounded_double_ended_queue.sv -----
// Top level of the bounded deque: control, storage, read stage and output register.
//
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   action[1:0], data_in[31:0]
//  out_ch    out   valid/ready   data_out[31:0], status[1:0], occupancy[4:0]
//
// One item per cycle when the result side keeps up; each result passes through the
// read stage, fed by the registered read of the storage RAM, and the output register.
// Pointers and fill count clear on arst_n; the RAM needs no clearing pass.
// A stalled result holds the output register and then the read stage; the input
// is held off only once both are occupied.
module bounded_double_ended_queue #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_in_if.sink    in_ch,
	bdq_out_if.source out_ch
);
	import bdq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              accept;
	logic              advance;
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;
	res_t              res;

	logic              valid_s1;
	res_t              res_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	status_t           out_status_q;
	logic [OCC_W-1:0]  out_occ_q;

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;
	assign accept      = in_ch.valid && in_ch.ready;

	bdq_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (in_ch.action),
		.data_in   (in_ch.data_in),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.res       (res)
	);

	bdq_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Read stage: wait for the RAM word, hold while the output register is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q   <= res_s1.pop_ok ? mem_rdata : '0;
			out_status_q <= res_s1.status;
			out_occ_q    <= res_s1.occupancy;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.data_out  = out_data_q;
	assign out_ch.status    = out_status_q;
	assign out_ch.occupancy = out_occ_q;
endmodule

// ----- verif/tb_bounded_double_ended_queue.sv -----
// Self-checking testbench for the bounded deque: random push/pop traffic against a shadow deque.
module tb_bounded_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import bdq_pkg::*;

	localparam int DEPTH      = DEPTH_DEFAULT;
	localparam int N_RANDOM   = 2000;
	localparam int STALL_MAX  = 8;
	localparam int IDLE_LIMIT = 400;
	localparam int DRAIN_CYC  = 12;

	typedef struct {
		action_t            act;
		logic signed [31:0] word;
	} deque_op_t;

	typedef struct {
		logic signed [31:0] word;
		status_t            st;
		logic [OCC_W-1:0]   occ;
	} deque_result_t;

	logic clk;
	logic arst_n;

	bdq_in_if  in_ch();
	bdq_out_if out_ch();

	bounded_double_ended_queue #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	deque_op_t          deque_ops_q[$];
	deque_result_t      expected_results_q[$];

	// shadow deque
	logic signed [31:0] shadow_mem [DEPTH];
	int                 shadow_head;
	int                 shadow_fill;

	int n_ops_total;
	int n_ops_taken;
	int n_results;
	int n_errors;
	int n_push_ok, n_pop_ok, n_full_refused, n_empty_refused;
	int peak_fill;
	int idle_cycles;

	logic in_taken;
	logic out_taken;
	int   in_gap;
	int   out_gap;
	bit   in_calm;
	bit   out_calm;

	function automatic int draw_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, STALL_MAX);
	endfunction

	// Apply one operation to the shadow deque and return the result it should give.
	function automatic deque_result_t apply_to_shadow_deque(input deque_op_t op);
		deque_result_t r;
		r.word = '0;
		r.st   = ST_DONE;
		case (op.act)
			ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
				if (shadow_fill >= DEPTH) begin
					r.st = ST_FULL;
					n_full_refused++;
				end else begin
					if (op.act == ACT_PUSH_FRONT) begin
						shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
						shadow_mem[shadow_head] = op.word;
					end else begin
						shadow_mem[(shadow_head + shadow_fill) % DEPTH] = op.word;
					end
					shadow_fill++;
					n_push_ok++;
				end
			end
			default: begin
				if (shadow_fill == 0) begin
					r.st = ST_EMPTY;
					n_empty_refused++;
				end else begin
					if (op.act == ACT_POP_FRONT) begin
						r.word = shadow_mem[shadow_head];
						shadow_head = (shadow_head + 1) % DEPTH;
					end else begin
						r.word = shadow_mem[(shadow_head + shadow_fill - 1) % DEPTH];
					end
					shadow_fill--;
					n_pop_ok++;
				end
			end
		endcase
		if (shadow_fill > peak_fill)
			peak_fill = shadow_fill;
		r.occ = OCC_W'(shadow_fill);
		return r;
	endfunction

	function automatic logic signed [31:0] draw_word();
		case ($urandom_range(0, 19))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_op(input action_t act, input logic signed [31:0] word);
		deque_op_t op;
		op.act  = act;
		op.word = word;
		deque_ops_q.push_back(op);
	endtask

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.action   = ACT_PUSH_FRONT;
		in_ch.data_in  = '0;
		out_ch.ready   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Stimulus
	initial begin
		int burst_left;
		int push_pct;
		shadow_head = 0;
		shadow_fill = 0;
		n_errors = 0;
		n_ops_taken = 0;
		n_results = 0;
		n_push_ok = 0;
		n_pop_ok = 0;
		n_full_refused = 0;
		n_empty_refused = 0;
		peak_fill = 0;

		// empty deque: both pops refused
		add_op(ACT_POP_FRONT, 32'sh1234_5678);
		add_op(ACT_POP_REAR, 32'sh7fff_ffff);
		// extreme words through each end
		add_op(ACT_PUSH_FRONT, 32'sh8000_0000);
		add_op(ACT_PUSH_REAR, 32'sh7fff_ffff);
		add_op(ACT_POP_FRONT, '0);
		add_op(ACT_POP_REAR, '0);
		// fill to the brim from both ends, then push into a full deque
		for (int i = 0; i < DEPTH; i++)
			add_op((i % 2) ? ACT_PUSH_REAR : ACT_PUSH_FRONT,
				(i == 0) ? 32'sh0 : (i == 1) ? -32'sd1 : $urandom);
		add_op(ACT_PUSH_FRONT, 32'sh5555_5555);
		add_op(ACT_PUSH_REAR, 32'shaaaa_aaaa);

		// random bursts biased towards filling, churning or draining
		burst_left = 0;
		push_pct = 50;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (burst_left == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 15;
				endcase
				burst_left = $urandom_range(20, 80);
			end
			burst_left--;
			if ($urandom_range(0, 99) < push_pct)
				add_op($urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, draw_word());
			else
				add_op($urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT, draw_word());
		end
		n_ops_total = deque_ops_q.size();

		while (n_ops_taken < n_ops_total)
			@(posedge clk);
		while (expected_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("%0d items: %0d pushes stored, %0d words popped, peak fill %0d of %0d",
			n_ops_total, n_push_ok, n_pop_ok, peak_fill, DEPTH);
		$display("refusals: %0d full, %0d empty; %0d results checked, %0d mismatches",
			n_full_refused, n_empty_refused, n_results, n_errors);
		if (n_errors == 0)
			$display("tb_bounded_double_ended_queue OK");
		else
			$display("tb_bounded_double_ended_queue NOT OK");
		$finish;
	end

	// Sample handshakes, predict on accepted items and check accepted results
	always @(posedge clk) begin
		deque_result_t exp_r;
		if (arst_n) begin
			in_taken  <= in_ch.valid && in_ch.ready;
			out_taken <= out_ch.valid && out_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				deque_op_t op;
				op.act  = action_t'(in_ch.action);
				op.word = in_ch.data_in;
				expected_results_q.push_back(apply_to_shadow_deque(op));
				n_ops_taken++;
			end
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (expected_results_q.size() == 0) begin
					n_errors++;
					$display("%t: unexpected result data_out=%0d status=%0d occupancy=%0d",
						$time, out_ch.data_out, out_ch.status, out_ch.occupancy);
				end else begin
					exp_r = expected_results_q.pop_front();
					if (out_ch.data_out !== exp_r.word) begin
						n_errors++;
						$display("%t: data_out expected %0d got %0d",
							$time, exp_r.word, out_ch.data_out);
					end
					if (out_ch.status !== exp_r.st) begin
						n_errors++;
						$display("%t: status expected %0d got %0d",
							$time, exp_r.st, out_ch.status);
					end
					if (out_ch.occupancy !== exp_r.occ) begin
						n_errors++;
						$display("%t: occupancy expected %0d got %0d",
							$time, exp_r.occ, out_ch.occupancy);
					end
				end
			end
		end else begin
			in_taken  <= 1'b0;
			out_taken <= 1'b0;
		end
	end

	// Input driver
	always @(negedge clk) begin
		deque_op_t op;
		if (arst_n !== 1'b1) begin
			in_ch.valid <= 1'b0;
			in_gap      <= 0;
			in_calm     <= 1'b0;
		end else if (in_ch.valid && !in_taken) begin
			// hold the item until it is taken
		end else if (in_gap != 0) begin
			in_ch.valid <= 1'b0;
			in_gap      <= in_gap - 1;
		end else if (deque_ops_q.size() != 0) begin
			op = deque_ops_q.pop_front();
			in_ch.valid   <= 1'b1;
			in_ch.action  <= op.act;
			in_ch.data_in <= op.word;
			if ($urandom_range(0, 63) == 0)
				in_calm <= !in_calm;
			in_gap <= draw_wait(in_calm);
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Result-side back-pressure
	always @(negedge clk) begin
		int g;
		if (arst_n !== 1'b1) begin
			out_ch.ready <= 1'b0;
			out_gap      <= 0;
			out_calm     <= 1'b0;
		end else if (out_taken) begin
			if ($urandom_range(0, 63) == 0)
				out_calm <= !out_calm;
			g = draw_wait(out_calm);
			out_ch.ready <= (g == 0);
			out_gap      <= (g == 0) ? 0 : g - 1;
		end else if (out_gap != 0) begin
			out_ch.ready <= 1'b0;
			out_gap      <= out_gap - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Watchdog: give up when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_bounded_double_ended_queue NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ----- filelist.f -----
src/bdq_pkg.sv
src/bdq_in_if.sv
src/bdq_out_if.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bounded_double_ended_queue.sv
verif/tb_bounded_double_ended_queue.sv
